// ===== hw/rtl/dtc_pkg.sv =====
// ----------------------------------------------------------------------------
// Direction to cube tile: shared package
// Field widths, result codes and the transfer structs used by every stage.
// ----------------------------------------------------------------------------
package dtc_pkg;

    // Fixed widths of the command and result fields
    localparam int COMP_BITS   = 24;
    localparam int LEVEL_BITS  = 5;
    localparam int LAYER_BITS  = 4;
    localparam int FACE_BITS   = 3;
    localparam int TILE_BITS   = 30;
    localparam int ERR_BITS    = 2;

    // Default deepest subdivision level
    localparam int MAX_LEVEL_DEFAULT = 30;

    // Cube face codes
    typedef enum logic [FACE_BITS-1:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    // Error codes
    typedef enum logic [ERR_BITS-1:0] {
        ERR_NONE  = 2'd0,
        ERR_ZERO  = 2'd1,
        ERR_LEVEL = 2'd2
    } err_t;

    // One command transfer
    typedef struct packed {
        logic signed [COMP_BITS-1:0]  dir_x;
        logic signed [COMP_BITS-1:0]  dir_y;
        logic signed [COMP_BITS-1:0]  dir_z;
        logic        [LEVEL_BITS-1:0] tile_level;
        logic        [LAYER_BITS-1:0] layer_tag;
    } dir_in_t;

    // One result transfer
    typedef struct packed {
        logic [FACE_BITS-1:0]  face;
        logic [LEVEL_BITS-1:0] level_out;
        logic [TILE_BITS-1:0]  tile_x;
        logic [TILE_BITS-1:0]  tile_y;
        logic [LAYER_BITS-1:0] layer_out;
        logic [ERR_BITS-1:0]   error;
    } tile_out_t;

    // Item tags that ride alongside the division chain
    typedef struct packed {
        face_t                 face;
        logic [LEVEL_BITS-1:0] level;
        logic [LAYER_BITS-1:0] layer;
        err_t                  err;
        logic                  qint_u;
        logic                  qint_v;
    } side_t;

endpackage

// ===== hw/rtl/dtc_prep.sv =====
// ----------------------------------------------------------------------------
// Direction to cube tile: face selection and divider set-up
// Two register stages: pick the face and numerators, then form the shifted
// numerators, the divisor and the whole-face-edge flags for the cell chain.
// ----------------------------------------------------------------------------
module dtc_prep #(
    parameter int MAX_LEVEL = dtc_pkg::MAX_LEVEL_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  dtc_pkg::dir_in_t               cmd,
    output logic                           out_valid,
    output dtc_pkg::side_t                 out_side,
    output logic [dtc_pkg::COMP_BITS:0]    out_d,
    output logic [dtc_pkg::COMP_BITS:0]    out_ru,
    output logic [dtc_pkg::COMP_BITS:0]    out_rv
);

    localparam int CB = dtc_pkg::COMP_BITS;
    localparam logic [dtc_pkg::LEVEL_BITS-1:0] MAX_LVL =
        dtc_pkg::LEVEL_BITS'(MAX_LEVEL);

    // Stage one registers
    logic                              s1_valid_reg;
    logic [CB-1:0]                     m_reg;
    logic signed [CB:0]                u_reg;
    logic signed [CB:0]                v_reg;
    dtc_pkg::face_t                    face_reg;
    logic [dtc_pkg::LEVEL_BITS-1:0]    level_reg;
    logic [dtc_pkg::LAYER_BITS-1:0]    layer_reg;
    dtc_pkg::err_t                     err_reg;

    logic [CB-1:0]                     m_next;
    logic signed [CB:0]                u_next;
    logic signed [CB:0]                v_next;
    dtc_pkg::face_t                    face_next;
    dtc_pkg::err_t                     err_next;

    // Stage two registers
    logic                              s2_valid_reg;
    dtc_pkg::side_t                    side_reg;
    logic [CB:0]                       d_reg;
    logic [CB:0]                       ru_reg;
    logic [CB:0]                       rv_reg;

    dtc_pkg::side_t                    side_next;
    logic [CB:0]                       d_next;
    logic [CB:0]                       ru_next;
    logic [CB:0]                       rv_next;

    logic signed [CB:0]                xs;
    logic signed [CB:0]                ys;
    logic signed [CB:0]                zs;
    logic signed [CB:0]                ax_full;
    logic signed [CB:0]                ay_full;
    logic signed [CB:0]                az_full;
    logic [CB-1:0]                     ax;
    logic [CB-1:0]                     ay;
    logic [CB-1:0]                     az;
    logic signed [CB+1:0]              nu;
    logic signed [CB+1:0]              nv;

    // Magnitudes, face choice and signed numerators
    always_comb
    begin
        xs      = {cmd.dir_x[CB-1], cmd.dir_x};
        ys      = {cmd.dir_y[CB-1], cmd.dir_y};
        zs      = {cmd.dir_z[CB-1], cmd.dir_z};
        ax_full = xs[CB] ? -xs : xs;
        ay_full = ys[CB] ? -ys : ys;
        az_full = zs[CB] ? -zs : zs;
        ax      = ax_full[CB-1:0];
        ay      = ay_full[CB-1:0];
        az      = az_full[CB-1:0];

        if (ax >= ay && ax >= az)
        begin
            m_next = ax;
            v_next = ys;
            if (!xs[CB])
            begin
                face_next = dtc_pkg::FACE_POS_X;
                u_next    = -zs;
            end
            else
            begin
                face_next = dtc_pkg::FACE_NEG_X;
                u_next    = zs;
            end
        end
        else if (ay >= az)
        begin
            m_next = ay;
            u_next = xs;
            if (!ys[CB])
            begin
                face_next = dtc_pkg::FACE_POS_Y;
                v_next    = -zs;
            end
            else
            begin
                face_next = dtc_pkg::FACE_NEG_Y;
                v_next    = zs;
            end
        end
        else
        begin
            m_next = az;
            v_next = ys;
            if (!zs[CB])
            begin
                face_next = dtc_pkg::FACE_POS_Z;
                u_next    = xs;
            end
            else
            begin
                face_next = dtc_pkg::FACE_NEG_Z;
                u_next    = -xs;
            end
        end

        // A level out of range wins over a zero vector.
        if (cmd.tile_level > MAX_LVL)
        begin
            err_next = dtc_pkg::ERR_LEVEL;
        end
        else if (ax == '0 && ay == '0 && az == '0)
        begin
            err_next = dtc_pkg::ERR_ZERO;
        end
        else
        begin
            err_next = dtc_pkg::ERR_NONE;
        end
    end

    // Stage one valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Stage one payload
    always_ff @(posedge clk)
    begin
        m_reg     <= m_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        face_reg  <= face_next;
        level_reg <= cmd.tile_level;
        layer_reg <= cmd.layer_tag;
        err_reg   <= err_next;
    end

    // Offset numerators into [0, 2m] and start the remainders. The value
    // exactly at the face edge gives a whole quotient and is flagged.
    always_comb
    begin
        nu      = {u_reg[CB], u_reg} + $signed({2'b00, m_reg});
        nv      = {v_reg[CB], v_reg} + $signed({2'b00, m_reg});
        d_next  = {m_reg, 1'b0};

        side_next.face   = face_reg;
        side_next.level  = level_reg;
        side_next.layer  = layer_reg;
        side_next.err    = err_reg;
        side_next.qint_u = (nu[CB:0] == d_next);
        side_next.qint_v = (nv[CB:0] == d_next);

        ru_next = side_next.qint_u ? '0 : nu[CB:0];
        rv_next = side_next.qint_v ? '0 : nv[CB:0];
    end

    // Stage two valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage two payload
    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        d_reg    <= d_next;
        ru_reg   <= ru_next;
        rv_reg   <= rv_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_side  = side_reg;
    assign out_d     = d_reg;
    assign out_ru    = ru_reg;
    assign out_rv    = rv_reg;

endmodule

// ===== hw/rtl/dtc_cell.sv =====
// ----------------------------------------------------------------------------
// Direction to cube tile: division cell
// One restoring-division step for both tile coordinates: doubles each
// remainder, compares with the divisor and appends one quotient bit.
// ----------------------------------------------------------------------------
module dtc_cell #(
    parameter int QBITS = dtc_pkg::MAX_LEVEL_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  dtc_pkg::side_t                 in_side,
    input  logic [dtc_pkg::COMP_BITS:0]    in_d,
    input  logic [dtc_pkg::COMP_BITS:0]    in_ru,
    input  logic [dtc_pkg::COMP_BITS:0]    in_rv,
    input  logic [QBITS-1:0]               in_qu,
    input  logic [QBITS-1:0]               in_qv,
    output logic                           out_valid,
    output dtc_pkg::side_t                 out_side,
    output logic [dtc_pkg::COMP_BITS:0]    out_d,
    output logic [dtc_pkg::COMP_BITS:0]    out_ru,
    output logic [dtc_pkg::COMP_BITS:0]    out_rv,
    output logic [QBITS-1:0]               out_qu,
    output logic [QBITS-1:0]               out_qv
);

    localparam int CB = dtc_pkg::COMP_BITS;

    logic                valid_reg;
    dtc_pkg::side_t      side_reg;
    logic [CB:0]         d_reg;
    logic [CB:0]         ru_reg;
    logic [CB:0]         rv_reg;
    logic [QBITS-1:0]    qu_reg;
    logic [QBITS-1:0]    qv_reg;

    logic [CB:0]         ru_next;
    logic [CB:0]         rv_next;
    logic [QBITS-1:0]    qu_next;
    logic [QBITS-1:0]    qv_next;

    logic [CB+1:0]       ru2;
    logic [CB+1:0]       rv2;
    logic [CB+1:0]       dw;
    logic                ge_u;
    logic                ge_v;
    logic [CB+1:0]       ru_sub;
    logic [CB+1:0]       rv_sub;
    logic [QBITS:0]      qu_sh;
    logic [QBITS:0]      qv_sh;

    // One quotient bit per coordinate
    always_comb
    begin
        ru2    = {in_ru, 1'b0};
        rv2    = {in_rv, 1'b0};
        dw     = {1'b0, in_d};
        ge_u   = (ru2 >= dw);
        ge_v   = (rv2 >= dw);
        ru_sub = ge_u ? (ru2 - dw) : ru2;
        rv_sub = ge_v ? (rv2 - dw) : rv2;
        ru_next = ru_sub[CB:0];
        rv_next = rv_sub[CB:0];
        qu_sh  = {in_qu, ge_u};
        qv_sh  = {in_qv, ge_v};
        qu_next = qu_sh[QBITS-1:0];
        qv_next = qv_sh[QBITS-1:0];
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Data handed on to the next cell
    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        d_reg    <= in_d;
        ru_reg   <= ru_next;
        rv_reg   <= rv_next;
        qu_reg   <= qu_next;
        qv_reg   <= qv_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_d     = d_reg;
    assign out_ru    = ru_reg;
    assign out_rv    = rv_reg;
    assign out_qu    = qu_reg;
    assign out_qv    = qv_reg;

endmodule

// ===== hw/rtl/dtc_pack.sv =====
// ----------------------------------------------------------------------------
// Direction to cube tile: result stage
// Scales the full-precision quotients down to the requested level, applies
// the face-edge clamp and error masking, and registers the result.
// ----------------------------------------------------------------------------
module dtc_pack #(
    parameter int MAX_LEVEL = dtc_pkg::MAX_LEVEL_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  dtc_pkg::side_t         in_side,
    input  logic [MAX_LEVEL-1:0]   in_qu,
    input  logic [MAX_LEVEL-1:0]   in_qv,
    output logic                   done,
    output dtc_pkg::tile_out_t     result
);

    localparam logic [dtc_pkg::LEVEL_BITS-1:0] MAX_LVL =
        dtc_pkg::LEVEL_BITS'(MAX_LEVEL);

    logic                          done_reg;
    dtc_pkg::tile_out_t            result_reg;
    dtc_pkg::tile_out_t            result_next;

    logic [dtc_pkg::LEVEL_BITS-1:0] shift;
    logic [MAX_LEVEL-1:0]          qu_eff;
    logic [MAX_LEVEL-1:0]          qv_eff;
    logic [MAX_LEVEL-1:0]          tu;
    logic [MAX_LEVEL-1:0]          tv;

    // Keep the top level bits of each quotient; a whole quotient at the face
    // edge becomes the last tile, which is all ones at that level.
    always_comb
    begin
        shift  = MAX_LVL - in_side.level;
        qu_eff = in_side.qint_u ? '1 : in_qu;
        qv_eff = in_side.qint_v ? '1 : in_qv;
        tu     = qu_eff >> shift;
        tv     = qv_eff >> shift;

        result_next.layer_out = in_side.layer;
        result_next.error     = in_side.err;
        if (in_side.err == dtc_pkg::ERR_NONE)
        begin
            result_next.face      = in_side.face;
            result_next.level_out = in_side.level;
            result_next.tile_x    = dtc_pkg::TILE_BITS'(tu);
            result_next.tile_y    = dtc_pkg::TILE_BITS'(tv);
        end
        else
        begin
            result_next.face      = '0;
            result_next.level_out = '0;
            result_next.tile_x    = '0;
            result_next.tile_y    = '0;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== hw/rtl/direction_to_cube_tile.sv =====
// ----------------------------------------------------------------------------
// Direction to cube tile: top level
// Picks the cube face of a direction vector and quantises its face
// coordinates into a tile index through a chain of division cells.
// ----------------------------------------------------------------------------
// A command passes through the prep stages, one division cell per quotient bit and
// the result register before its done strobe.
// Throughput: one command per cycle; busy is never raised.
// The receiver cannot stall; every result shows for exactly one cycle.
// Reset clears only the valid flags along the chain; no result is lost or
// invented after reset and no clearing pass is needed.
module direction_to_cube_tile #(
    parameter int MAX_LEVEL = dtc_pkg::MAX_LEVEL_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  dtc_pkg::dir_in_t       cmd,
    output logic                   done,
    output dtc_pkg::tile_out_t     result
);

    localparam int CB      = dtc_pkg::COMP_BITS;
    localparam int LATENCY = MAX_LEVEL + 3;

    // Taps between neighbouring cells
    logic                  c_valid [MAX_LEVEL+1];
    dtc_pkg::side_t        c_side  [MAX_LEVEL+1];
    logic [CB:0]           c_d     [MAX_LEVEL+1];
    logic [CB:0]           c_ru    [MAX_LEVEL+1];
    logic [CB:0]           c_rv    [MAX_LEVEL+1];
    logic [MAX_LEVEL-1:0]  c_qu    [MAX_LEVEL+1];
    logic [MAX_LEVEL-1:0]  c_qv    [MAX_LEVEL+1];

    // The pipeline never holds off a command.
    assign busy = 1'b0;

    // Face selection and divider set-up
    dtc_prep #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .cmd       (cmd),
        .out_valid (c_valid[0]),
        .out_side  (c_side[0]),
        .out_d     (c_d[0]),
        .out_ru    (c_ru[0]),
        .out_rv    (c_rv[0])
    );

    assign c_qu[0] = '0;
    assign c_qv[0] = '0;

    // Chain of division cells, one quotient bit each
    for (genvar i = 0; i < MAX_LEVEL; i++)
    begin : g_cell
        dtc_cell #(
            .QBITS (MAX_LEVEL)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_side   (c_side[i]),
            .in_d      (c_d[i]),
            .in_ru     (c_ru[i]),
            .in_rv     (c_rv[i]),
            .in_qu     (c_qu[i]),
            .in_qv     (c_qv[i]),
            .out_valid (c_valid[i+1]),
            .out_side  (c_side[i+1]),
            .out_d     (c_d[i+1]),
            .out_ru    (c_ru[i+1]),
            .out_rv    (c_rv[i+1]),
            .out_qu    (c_qu[i+1]),
            .out_qv    (c_qv[i+1])
        );
    end

    // Result stage
    dtc_pack #(
        .MAX_LEVEL (MAX_LEVEL)
    ) u_pack (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (c_valid[MAX_LEVEL]),
        .in_side  (c_side[MAX_LEVEL]),
        .in_qu    (c_qu[MAX_LEVEL]),
        .in_qv    (c_qv[MAX_LEVEL]),
        .done     (done),
        .result   (result)
    );

    // Every accepted command produces its result a fixed time later.
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result strobe missing after command transfer");

    // An error result carries no face or tile.
    a_err_clear : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.error != dtc_pkg::ERR_NONE |->
            result.face == '0 && result.tile_x == '0 && result.tile_y == '0
            && result.level_out == '0)
        else $error("error result with non-zero tile fields");

    // A good result lies inside its level's tile grid.
    a_tile_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.error == dtc_pkg::ERR_NONE |->
            (result.tile_x >> result.level_out) == '0
            && (result.tile_y >> result.level_out) == '0)
        else $error("tile index outside the grid of its level");

    // A good result names a real face and a level within range.
    a_face_range : assert property (@(posedge clk) disable iff (!rst_n)
        done && result.error == dtc_pkg::ERR_NONE |->
            result.face <= dtc_pkg::FACE_NEG_Z && result.level_out <= MAX_LEVEL)
        else $error("good result with an invalid face or level");

endmodule

// ===== test/dtc_tile_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direction to cube tile: result checker
// Watches the command and result channels of the block. Every accepted
// command is turned into an expected tile by an independent predictor, and
// every result strobe is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module dtc_tile_checker
    import dtc_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      busy,
    input  dir_in_t   cmd,
    input  logic      done,
    input  tile_out_t result,
    output int        mismatches,
    output int        pending,
    output int        checked,
    output logic [5:0] faces_seen,
    output logic [2:0] errs_seen
);

    // Tiles still owed by the block, oldest first
    tile_out_t tile_q[$];
    int        fail_cnt = 0;
    int        pend_cnt = 0;
    int        check_cnt = 0;
    logic [5:0] face_mask = '0;
    logic [2:0] err_mask = '0;

    assign mismatches = fail_cnt;
    assign pending    = pend_cnt;
    assign checked    = check_cnt;
    assign faces_seen = face_mask;
    assign errs_seen  = err_mask;

    // Tile index along one face axis: floor((c + m) * 2^level / 2m), kept
    // below 2^level so that the face edge lands in the last tile.
    function automatic logic [TILE_BITS-1:0] tile_index(
        input logic signed [63:0] c,
        input logic signed [63:0] m,
        input int unsigned        lvl
    );
        logic [63:0] num;
        logic [63:0] idx;
        logic [63:0] last;
        num  = 64'(c + m) << lvl;
        idx  = num / (64'(m) << 1);
        last = (64'd1 << lvl) - 64'd1;
        if (idx > last)
            idx = last;
        return idx[TILE_BITS-1:0];
    endfunction

    // Expected result of one command
    function automatic tile_out_t predict_tile(input dir_in_t c);
        logic signed [63:0] x, y, z;
        logic signed [63:0] ax, ay, az;
        logic signed [63:0] m, u, v;
        face_t              f;
        tile_out_t          r;
        x  = {{40{c.dir_x[COMP_BITS-1]}}, c.dir_x};
        y  = {{40{c.dir_y[COMP_BITS-1]}}, c.dir_y};
        z  = {{40{c.dir_z[COMP_BITS-1]}}, c.dir_z};
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r = '0;
        r.layer_out = c.layer_tag;
        if (c.tile_level > MAX_LEVEL)
        begin
            r.error = ERR_LEVEL;
        end
        else if (ax == 0 && ay == 0 && az == 0)
        begin
            r.error = ERR_ZERO;
        end
        else
        begin
            // Dominant axis; equal magnitudes favour X, then Y
            if (ax >= ay && ax >= az)
            begin
                m = ax;
                v = y;
                if (x >= 0)
                begin
                    f = FACE_POS_X;
                    u = -z;
                end
                else
                begin
                    f = FACE_NEG_X;
                    u = z;
                end
            end
            else if (ay >= az)
            begin
                m = ay;
                u = x;
                if (y >= 0)
                begin
                    f = FACE_POS_Y;
                    v = -z;
                end
                else
                begin
                    f = FACE_NEG_Y;
                    v = z;
                end
            end
            else
            begin
                m = az;
                v = y;
                if (z >= 0)
                begin
                    f = FACE_POS_Z;
                    u = x;
                end
                else
                begin
                    f = FACE_NEG_Z;
                    u = -x;
                end
            end
            r.error     = ERR_NONE;
            r.face      = f;
            r.level_out = c.tile_level;
            r.tile_x    = tile_index(u, m, c.tile_level);
            r.tile_y    = tile_index(v, m, c.tile_level);
        end
        return r;
    endfunction

    // One field of a result against its expected value
    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, fname, want, got);
        end
    endtask

    // Result transfers are compared before new commands are queued, so that
    // a stray strobe can never be matched against a command of this cycle.
    always @(posedge clk)
    begin : watch
        tile_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (tile_q.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t: result with none expected, expected nothing, actual %p",
                             $time, result);
                end
                else
                begin
                    want = tile_q.pop_front();
                    check_cnt++;
                    check_field("face",      want.face,      result.face);
                    check_field("level_out", want.level_out, result.level_out);
                    check_field("tile_x",    want.tile_x,    result.tile_x);
                    check_field("tile_y",    want.tile_y,    result.tile_y);
                    check_field("layer_out", want.layer_out, result.layer_out);
                    check_field("error",     want.error,     result.error);
                    err_mask[want.error] = 1'b1;
                    if (want.error == ERR_NONE)
                        face_mask[want.face] = 1'b1;
                end
            end
            if (start && !busy)
                tile_q.push_back(predict_tile(cmd));
            pend_cnt = tile_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Direction to cube tile: testbench top
// Drives directed corner cases and then shaped random direction vectors into
// the block, with random idle cycles, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    import dtc_pkg::*;

    localparam int LATENCY     = MAX_LEVEL_DEFAULT + 3;
    localparam int RANDOM_CMDS = 1850;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    dir_in_t   cmd = '0;
    logic      done;
    tile_out_t result;

    int         mismatches;
    int         pending;
    int         checked;
    logic [5:0] faces_seen;
    logic [2:0] errs_seen;
    int         sent = 0;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    direction_to_cube_tile dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    dtc_tile_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .faces_seen (faces_seen),
        .errs_seen  (errs_seen)
    );

    // Build a command from plain integers
    function automatic dir_in_t dir_cmd(input int x, input int y, input int z,
                                        input int lvl, input int layer);
        dir_in_t c;
        c.dir_x      = x[COMP_BITS-1:0];
        c.dir_y      = y[COMP_BITS-1:0];
        c.dir_z      = z[COMP_BITS-1:0];
        c.tile_level = lvl[LEVEL_BITS-1:0];
        c.layer_tag  = layer[LAYER_BITS-1:0];
        return c;
    endfunction

    // One component, mostly full scale, with small values and extremes mixed
    // in so that ties and face edges come up often.
    function automatic logic [COMP_BITS-1:0] pick_component();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3, 4: return COMP_BITS'($urandom);
            5, 6:          return COMP_BITS'($urandom_range(0, 16) - 8);
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return 24'h000001;
                    3:       return 24'hFFFFFF;
                    default: return 24'h000000;
                endcase
            end
            default:       return COMP_BITS'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    // Random command: occasional zero vectors and forced magnitude ties
    function automatic dir_in_t random_cmd();
        dir_in_t c;
        int      r;
        c.dir_x = pick_component();
        c.dir_y = pick_component();
        c.dir_z = pick_component();
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            c.dir_x = '0;
            c.dir_y = '0;
            c.dir_z = '0;
        end
        else if (r < 8)
            c.dir_y = $urandom_range(0, 1) ? c.dir_x : -c.dir_x;
        else if (r < 13)
            c.dir_z = $urandom_range(0, 1) ? c.dir_y : -c.dir_y;
        else if (r < 18)
            c.dir_z = $urandom_range(0, 1) ? c.dir_x : -c.dir_x;
        r = $urandom_range(0, 99);
        if (r < 6)
            c.tile_level = 5'd31;
        else if (r < 16)
            c.tile_level = 5'd30;
        else if (r < 24)
            c.tile_level = 5'd0;
        else
            c.tile_level = LEVEL_BITS'($urandom_range(0, 30));
        c.layer_tag = LAYER_BITS'($urandom_range(0, 15));
        return c;
    endfunction

    // Present one command and hold it until the transfer
    task automatic send_cmd(input dir_in_t c);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    // Random idle cycles between commands
    task automatic idle_gap(input bit allow);
        int n;
        n = 0;
        if (allow && $urandom_range(0, 99) < 20)
            n = $urandom_range(1, 3);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Directed corners followed by the random stream
    initial
    begin : stimulus
        dir_in_t directed[$];
        int      wait_cnt;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full-scale axis vectors on all six faces, at levels from 0 to 30
        directed.push_back(dir_cmd( 8388607, 0, 0,  0,  0));
        directed.push_back(dir_cmd(-8388608, 0, 0, 30, 15));
        directed.push_back(dir_cmd(0,  8388607, 0, 30,  9));
        directed.push_back(dir_cmd(0, -8388608, 0,  5,  1));
        directed.push_back(dir_cmd(0, 0,  8388607, 30,  2));
        directed.push_back(dir_cmd(0, 0, -8388608, 12,  3));
        // Zero vector, and a level above the maximum that wins over it
        directed.push_back(dir_cmd(0, 0, 0,  7,  4));
        directed.push_back(dir_cmd(0, 0, 0, 31,  5));
        directed.push_back(dir_cmd(5, 3, 1, 31,  6));
        // Magnitude ties, which also put a coordinate on the face edge
        directed.push_back(dir_cmd( 100, 100,  50, 10, 7));
        directed.push_back(dir_cmd(   1, -200, 200,  8, 8));
        directed.push_back(dir_cmd(  -7,  -7,  -7, 30, 10));
        directed.push_back(dir_cmd(  -1,   1,  -1,  3, 11));
        directed.push_back(dir_cmd(-8388608, -8388608, -8388608, 30, 12));
        directed.push_back(dir_cmd( 8388607,  8388607,  8388607,  1, 13));
        // Largest magnitude just beats the largest positive value
        directed.push_back(dir_cmd(8388607, -8388608, 8388607, 30, 14));
        // Centre of a face at the deepest level, and level zero
        directed.push_back(dir_cmd(1, 0, 0, 30, 0));
        directed.push_back(dir_cmd(0, 0, -1, 0, 1));
        directed.push_back(dir_cmd(3, -3, 2, 30, 9));
        directed.push_back(dir_cmd(-3, 2, 1, 29, 6));

        foreach (directed[i])
        begin
            send_cmd(directed[i]);
            idle_gap(1'b1);
        end

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            // Let the pipeline drain completely once mid-run
            if (i == 1200)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            send_cmd(random_cmd());
            idle_gap(i < 400 || i >= 900);
        end

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);

        // Watch for stray results after the last expected one
        wait_cnt = 0;
        while (wait_cnt < LATENCY + 8)
        begin
            @(posedge clk);
            wait_cnt++;
        end

        $display("Drove %0d commands: corner vectors, ties, zero vectors, levels 0 to 31.",
                 sent);
        $display("Checked %0d results; faces hit %b, error codes hit %b.",
                 checked, faces_seen, errs_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Guard against a hung run
    initial
    begin : watchdog
        #2400000;
        $display("%0t: run timed out with %0d results outstanding", $time, pending);
        $display("Some tests failed");
        $finish;
    end

endmodule
